// ----- rtl/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg - shared types and constants for the life generation step block
// Command codes, register indexes, default sizes and the control/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int CMD_W     = 2;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

    typedef struct packed {
        logic clear_we;
        logic rd_en;
        logic rd_from_in;
        logic latch_in;
        logic rmw_we;
        logic adv_first;
        logic adv_step;
        logic below_ok;
        logic out_load;
        logic out_err;
        logic out_read;
    } lgs_ctl_t;

    typedef struct packed {
        logic in_range;
        logic out_full;
    } lgs_sts_t;

endpackage

`default_nettype wire

// ----- rtl/lgs_cmd_if.sv -----
// ----------------------------------------------------------------------------
// lgs_cmd_if - command channel
// Valid/ready channel carrying one command beat: opcode, cell and value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lgs_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [5:0] row;
    logic [5:0] col;
    logic       alive_in;

    modport source (output valid, output command, output row, output col,
                    output alive_in, input ready);
    modport sink (input valid, input command, input row, input col,
                  input alive_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/lgs_res_if.sv -----
// ----------------------------------------------------------------------------
// lgs_res_if - result channel
// Valid/ready channel carrying one result beat: cell value and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lgs_res_if;
    logic valid;
    logic ready;
    logic alive_out;
    logic status;

    modport source (output valid, output alive_out, output status, input ready);
    modport sink (input valid, input alive_out, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/life_generation_step_top.sv -----
// ----------------------------------------------------------------------------
// life_generation_step_top - Conway life grid, rule B3/S23
// Bounded grid with dead cells beyond its edges; write, read or advance.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : command beats (write cell, advance one generation, read cell)
//   res  : one result beat per command, cell value and range status
//   cfg  : row_count and column_count, written while the block is idle
// Steps per command, from accept to the result register:
//   write cell   memory read, then modified row written back
//   read cell    registered memory read
//   advance      one grid row per cycle through the
//                single write / single read port of the grid memory
//   out of range, unused code, or advance with no rows: result loaded on accept
// One command is in flight at a time; the next is taken once the result
// register is empty or being drained in that cycle.
// Reset: size registers go to 64 x 64, then a clearing pass writes every
//   grid row dead, during which cmd.ready stays low.
// Stall: a result held by res.ready low blocks the next command beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module life_generation_step_top #(
    parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lgs_pkg::CFG_W-1:0]       cfg_data,
    lgs_cmd_if.sink                              cmd,
    lgs_res_if.source                            res
);

    import lgs_pkg::*;

    localparam int RW = $clog2(MAX_ROWS + 1);

    lgs_ctl_t      ctl;
    lgs_sts_t      sts;
    logic [RW-1:0] rows;
    logic [RW-1:0] ctr;
    logic [RW-1:0] rd_row;
    logic          in_ready;

    assign cmd.ready = in_ready;

    lgs_ctrl #(
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .command  (cmd.command),
        .in_ready (in_ready),
        .rows     (rows),
        .sts      (sts),
        .ctl      (ctl),
        .ctr      (ctr),
        .rd_row   (rd_row)
    );

    lgs_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row       (cmd.row),
        .col       (cmd.col),
        .alive_in  (cmd.alive_in),
        .out_ready (res.ready),
        .out_valid (res.valid),
        .alive_out (res.alive_out),
        .status    (res.status),
        .ctl       (ctl),
        .ctr       (ctr),
        .rd_row    (rd_row),
        .rows      (rows),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ----- rtl/lgs_next_row.sv -----
// ----------------------------------------------------------------------------
// lgs_next_row - next generation of one grid row
// One lane per column counts the eight neighbors from the rows above, at and
// below, and applies B3/S23; columns outside the mask keep their old value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgs_next_row #(
    parameter int MAX_COLS = 64
) (
    input  wire logic [MAX_COLS-1:0] prev,
    input  wire logic [MAX_COLS-1:0] cur,
    input  wire logic [MAX_COLS-1:0] below,
    input  wire logic [MAX_COLS-1:0] cur_raw,
    input  wire logic [MAX_COLS-1:0] mask,
    output logic      [MAX_COLS-1:0] next_word
);

    logic [MAX_COLS+1:0] p_pad;
    logic [MAX_COLS+1:0] c_pad;
    logic [MAX_COLS+1:0] b_pad;

    assign p_pad = {1'b0, prev, 1'b0};
    assign c_pad = {1'b0, cur, 1'b0};
    assign b_pad = {1'b0, below, 1'b0};

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
        logic [3:0] cnt;
        logic       live;

        assign cnt = 4'(p_pad[c]) + 4'(p_pad[c+1]) + 4'(p_pad[c+2])
                   + 4'(c_pad[c]) + 4'(c_pad[c+2])
                   + 4'(b_pad[c]) + 4'(b_pad[c+1]) + 4'(b_pad[c+2]);
        assign live = (cnt == 4'd3) || (c_pad[c+1] && (cnt == 4'd2));
        assign next_word[c] = mask[c] ? live : cur_raw[c];
    end

endmodule

`default_nettype wire

// ----- rtl/lgs_ctrl.sv -----
// ----------------------------------------------------------------------------
// lgs_ctrl - command sequencer
// Runs the clearing pass after reset, takes command beats, and steps the
// datapath through cell reads, read-modify-writes and the row-by-row advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgs_ctrl #(
    parameter int MAX_ROWS = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic [lgs_pkg::CMD_W-1:0]          command,
    output logic                                    in_ready,
    input  wire logic [$clog2(MAX_ROWS+1)-1:0]      rows,
    input  wire lgs_pkg::lgs_sts_t                  sts,
    output lgs_pkg::lgs_ctl_t                       ctl,
    output logic      [$clog2(MAX_ROWS+1)-1:0]      ctr,
    output logic      [$clog2(MAX_ROWS+1)-1:0]      rd_row
);

    import lgs_pkg::*;

    localparam int RW = $clog2(MAX_ROWS + 1);

    localparam logic [2:0] ST_CLEAR     = 3'd0;
    localparam logic [2:0] ST_IDLE      = 3'd1;
    localparam logic [2:0] ST_RMW       = 3'd2;
    localparam logic [2:0] ST_ADV_FIRST = 3'd3;
    localparam logic [2:0] ST_ADV_ROW   = 3'd4;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [RW-1:0] ctr_reg;
    logic [RW-1:0] ctr_next;
    logic          wr_pend_reg;
    logic          wr_pend_next;
    logic [RW:0]   ctr_inc;
    logic          last_row;
    logic          has_below;
    logic          clear_last;
    logic          accept;

    assign ctr        = ctr_reg;
    assign ctr_inc    = {1'b0, ctr_reg} + (RW+1)'(1);
    assign last_row   = (ctr_inc == {1'b0, rows});
    assign has_below  = (ctr_inc < {1'b0, rows});
    assign clear_last = (ctr_reg == RW'(MAX_ROWS - 1));
    assign in_ready   = (state_reg == ST_IDLE) && !sts.out_full;
    assign accept     = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        ctr_next     = ctr_reg;
        wr_pend_next = wr_pend_reg;
        ctl          = '0;
        rd_row       = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear_we = 1'b1;
                if (clear_last)
                begin
                    ctr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctr_next = RW'(ctr_inc);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctl.latch_in = 1'b1;
                    unique case (command) inside
                        CMD_WRITE, CMD_READ:
                        begin
                            if (sts.in_range)
                            begin
                                ctl.rd_en      = 1'b1;
                                ctl.rd_from_in = 1'b1;
                                wr_pend_next   = (command == CMD_WRITE);
                                state_next     = ST_RMW;
                            end
                            else
                            begin
                                ctl.out_load = 1'b1;
                                ctl.out_err  = 1'b1;
                            end
                        end
                        CMD_ADVANCE:
                        begin
                            if (rows == '0)
                            begin
                                ctl.out_load = 1'b1;
                            end
                            else
                            begin
                                ctl.rd_en  = 1'b1;
                                ctr_next   = '0;
                                state_next = ST_ADV_FIRST;
                            end
                        end
                        default:
                        begin
                            ctl.out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_RMW:
            begin
                ctl.out_load = 1'b1;
                ctl.rmw_we   = wr_pend_reg;
                ctl.out_read = !wr_pend_reg;
                state_next   = ST_IDLE;
            end
            ST_ADV_FIRST:
            begin
                ctl.adv_first = 1'b1;
                ctl.rd_en     = 1'b1;
                rd_row        = RW'(ctr_inc);
                state_next    = ST_ADV_ROW;
            end
            ST_ADV_ROW:
            begin
                ctl.adv_step = 1'b1;
                ctl.below_ok = has_below;
                ctl.rd_en    = 1'b1;
                rd_row       = RW'(ctr_inc + (RW+1)'(1));
                if (last_row)
                begin
                    ctl.out_load = 1'b1;
                    ctr_next     = '0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    ctr_next = RW'(ctr_inc);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            ctr_reg     <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ctr_reg     <= ctr_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lgs_dp.sv -----
// ----------------------------------------------------------------------------
// lgs_dp - grid store and generation datapath
// Size registers, the grid memory with one write and one registered read
// port, the three-row window for the advance and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgs_dp #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [lgs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lgs_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic [lgs_pkg::ROW_W-1:0]          row,
    input  wire logic [lgs_pkg::COL_W-1:0]          col,
    input  wire logic                               alive_in,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic                                    alive_out,
    output logic                                    status,
    input  wire lgs_pkg::lgs_ctl_t                  ctl,
    input  wire logic [$clog2(MAX_ROWS+1)-1:0]      ctr,
    input  wire logic [$clog2(MAX_ROWS+1)-1:0]      rd_row,
    output logic      [$clog2(MAX_ROWS+1)-1:0]      rows,
    output lgs_pkg::lgs_sts_t                       sts
);

    import lgs_pkg::*;

    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int AW  = $clog2(MAX_ROWS);
    localparam int CLW = $clog2(MAX_COLS + 1);
    localparam int CIW = $clog2(MAX_COLS);
    localparam int RCW = (RW > CFG_W) ? RW : CFG_W;
    localparam int CCW = (CLW > CFG_W) ? CLW : CFG_W;

    logic [CFG_W-1:0]    row_count_reg;
    logic [CFG_W-1:0]    column_count_reg;
    logic [CLW-1:0]      cols;
    logic [MAX_COLS-1:0] mask;

    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_COLS-1:0] mem_q_reg;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       waddr;
    logic [MAX_COLS-1:0] wdata;
    logic                we;

    logic [AW-1:0]       row_l_reg;
    logic [CIW-1:0]      col_l_reg;
    logic                alive_l_reg;
    logic [MAX_COLS-1:0] merged;

    logic [MAX_COLS-1:0] prev_reg;
    logic [MAX_COLS-1:0] cur_reg;
    logic [MAX_COLS-1:0] below;
    logic [MAX_COLS-1:0] next_word;

    logic                out_valid_reg;
    logic                alive_out_reg;
    logic                status_reg;

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= SIZE_RESET;
            column_count_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data;
            end
            if (cfg_index == CFG_COLUMN_COUNT)
            begin
                column_count_reg <= cfg_data;
            end
        end
    end

    assign rows = (RCW'(row_count_reg) > RCW'(MAX_ROWS)) ? RW'(MAX_ROWS)
                                                         : RW'(row_count_reg);
    assign cols = (CCW'(column_count_reg) > CCW'(MAX_COLS)) ? CLW'(MAX_COLS)
                                                            : CLW'(column_count_reg);

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
        assign mask[c] = (CLW'(c) < cols);
    end

    assign sts.in_range = (RCW'(row) < RCW'(rows)) && (CCW'(col) < CCW'(cols));
    assign sts.out_full = out_valid_reg && !out_ready;

    // latched cell of the pending read or write
    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            row_l_reg   <= AW'(row);
            col_l_reg   <= CIW'(col);
            alive_l_reg <= alive_in;
        end
    end

    always_comb
    begin
        merged            = mem_q_reg;
        merged[col_l_reg] = alive_l_reg;
    end

    // grid memory
    assign raddr = ctl.rd_from_in ? AW'(row) : AW'(rd_row);
    assign we    = ctl.clear_we || ctl.rmw_we || ctl.adv_step;
    assign waddr = ctl.rmw_we ? row_l_reg : AW'(ctr);
    assign wdata = ctl.clear_we ? '0 : (ctl.rmw_we ? merged : next_word);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            mem_q_reg <= mem[raddr];
        end
    end

    // three-row window
    always_ff @(posedge clk)
    begin
        if (ctl.adv_first)
        begin
            prev_reg <= '0;
            cur_reg  <= mem_q_reg;
        end
        else if (ctl.adv_step)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= mem_q_reg;
        end
    end

    assign below = ctl.below_ok ? (mem_q_reg & mask) : '0;

    lgs_next_row #(
        .MAX_COLS (MAX_COLS)
    ) u_next_row (
        .prev      (prev_reg & mask),
        .cur       (cur_reg & mask),
        .below     (below),
        .cur_raw   (cur_reg),
        .mask      (mask),
        .next_word (next_word)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            status_reg    <= ctl.out_err;
            alive_out_reg <= ctl.out_read && mem_q_reg[col_l_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign alive_out = alive_out_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire
